// ----- rtl/core/gss_pkg.sv -----
// Shared constants and widths for the grid spacing spread block.
`timescale 1ns / 1ps

package gss_pkg;

    localparam int MAX_COLUMNS     = 32;
    localparam int MAX_ROWS        = 32;
    localparam int COORD_FRAC_BITS = 8;

    localparam int COORD_W  = 20;
    localparam int PT_W     = 2 * COORD_W;
    localparam int CFG_W    = 6;
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DIST_W   = COORD_W + 1;
    localparam int DSUM_W   = 33;
    localparam int QSUM_W   = 52;
    localparam int CNT_W    = 12;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int WIDE_W   = 64;
    localparam int NN_W     = 2 * CNT_W;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;
    localparam int QHALF_W  = QSUM_W / 2;
    localparam int SCNT_W   = 6;
    localparam int DCNT_W   = 7;

    localparam logic [CFG_W-1:0]   COLUMNS_RESET = CFG_W'(9);
    localparam logic [CFG_W-1:0]   ROWS_RESET    = CFG_W'(5);
    localparam logic [COORD_W-1:0] SPREAD_MAX    = {COORD_W{1'b1}};

endpackage

// ----- rtl/core/grid_spacing_spread.sv -----
// Top level: standard deviation of neighbor spacings over a grid of corner points.
`timescale 1ns / 1ps

// Channel   Handshake                      Payload
// --------  -----------------------------  ---------------------------------
// item      item_valid / item_ready        x_coord, y_coord (Q12.8)
// result    result_valid / result_ready    spread (Q12.8), no_pairs
// config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One request at a time. A point handles up to two neighbor pairs; each pair
// squares both differences, takes the distance root and squares the distance on
// the shared 33x33 multiplier and the one-bit-per-cycle square root (21 steps).
// The last point of a grid then adds the setup states F1 to F5, the 64-step
// divider, 32 more root steps and the emit state. rst_n clears the control state
// and the configuration; the row store needs no clearing. A finished result waits
// in the output register while the next grid streams in; only the next grid's
// end stalls on it.
module grid_spacing_spread (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [gss_pkg::COORD_W-1:0]   x_coord,
    input  logic [gss_pkg::COORD_W-1:0]   y_coord,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [gss_pkg::COORD_W-1:0]   spread,
    output logic                          no_pairs,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_NEXT  = 5'd1;
    localparam logic [4:0] ST_DIFF  = 5'd2;
    localparam logic [4:0] ST_DX    = 5'd3;
    localparam logic [4:0] ST_DY    = 5'd4;
    localparam logic [4:0] ST_SUM   = 5'd5;
    localparam logic [4:0] ST_SQRT  = 5'd6;
    localparam logic [4:0] ST_ROUND = 5'd7;
    localparam logic [4:0] ST_DD    = 5'd8;
    localparam logic [4:0] ST_ACC   = 5'd9;
    localparam logic [4:0] ST_FINPT = 5'd10;
    localparam logic [4:0] ST_F1    = 5'd11;
    localparam logic [4:0] ST_F2    = 5'd12;
    localparam logic [4:0] ST_F3    = 5'd13;
    localparam logic [4:0] ST_F4    = 5'd14;
    localparam logic [4:0] ST_F5    = 5'd15;
    localparam logic [4:0] ST_DIV   = 5'd16;
    localparam logic [4:0] ST_RSQRT = 5'd17;
    localparam logic [4:0] ST_EMIT  = 5'd18;

    localparam int CW  = gss_pkg::COORD_W;
    localparam int PW  = gss_pkg::PT_W;
    localparam int FW  = gss_pkg::CFG_W;

    // Row store: points of the previous row, one entry per column.
    logic [PW-1:0] row_mem [gss_pkg::MAX_COLUMNS];
    logic [PW-1:0] mem_rd_reg;

    logic [4:0]                     state_reg;
    logic [FW-1:0]                  cols_cfg_reg, rows_cfg_reg;
    logic [gss_pkg::COL_W-1:0]      col_reg;
    logic [gss_pkg::ROW_W-1:0]      row_reg;
    logic [PW-1:0]                  pt_reg, left_reg, other_reg;
    logic                           left_pend_reg, above_pend_reg;
    logic [CW-1:0]                  dx_reg, dy_reg;
    logic [gss_pkg::WIDE_W-1:0]     sq_reg;
    logic [gss_pkg::DIST_W-1:0]     d_reg;
    logic [gss_pkg::DSUM_W-1:0]     dsum_reg;
    logic [gss_pkg::QSUM_W-1:0]     qsum_reg;
    logic [gss_pkg::CNT_W-1:0]      n_reg;
    logic [gss_pkg::PROD_W-1:0]     prod_reg;
    logic [gss_pkg::WIDE_W-1:0]     acc_reg, rhs_reg;
    logic [gss_pkg::NN_W-1:0]       nn_reg;

    // Shared square root: restoring, two radicand bits per step.
    logic [gss_pkg::WIDE_W-1:0]     sq_rad_reg;
    logic [gss_pkg::REM_W-1:0]      sq_rem_reg;
    logic [gss_pkg::ROOT_W-1:0]     sq_root_reg;
    logic [gss_pkg::SCNT_W-1:0]     sq_cnt_reg;

    // Divider: restoring, one quotient bit per step.
    logic [gss_pkg::WIDE_W-1:0]     dv_quo_reg;
    logic [gss_pkg::NN_W-1:0]       dv_rem_reg;
    logic [gss_pkg::DCNT_W-1:0]     dv_cnt_reg;

    logic                           out_valid_reg, out_flag_reg;
    logic [CW-1:0]                  out_spread_reg;

    logic                           item_take, cfg_write;
    logic [FW-1:0]                  cols_eff, rows_eff;
    logic                           last_col, last_row;
    logic [gss_pkg::MUL_W-1:0]      mul_a, mul_b;
    logic [CW-1:0]                  ox, oy, px, py;
    logic [gss_pkg::REM_W-1:0]      sq_rem_sh, sq_trial, sq_rem_next;
    logic                           sq_ge;
    logic [gss_pkg::NN_W:0]         dv_rem_sh;
    logic                           dv_ge;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_take    = item_valid && item_ready;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign pready       = 1'b1;
    assign prdata       = paddr[2] ? 32'(rows_cfg_reg) : 32'(cols_cfg_reg);
    assign result_valid = out_valid_reg;
    assign spread       = out_spread_reg;
    assign no_pairs     = out_flag_reg;

    // Clamp the grid size into 1..MAX.
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols_eff = FW'(1);
        else if (cols_cfg_reg > FW'(gss_pkg::MAX_COLUMNS))
            cols_eff = FW'(gss_pkg::MAX_COLUMNS);
        else
            cols_eff = cols_cfg_reg;
        if (rows_cfg_reg == '0)
            rows_eff = FW'(1);
        else if (rows_cfg_reg > FW'(gss_pkg::MAX_ROWS))
            rows_eff = FW'(gss_pkg::MAX_ROWS);
        else
            rows_eff = rows_cfg_reg;
    end

    assign last_col = (FW'(col_reg) + FW'(1)) >= cols_eff;
    assign last_row = (FW'(row_reg) + FW'(1)) >= rows_eff;

    assign px = pt_reg[CW-1:0];
    assign py = pt_reg[PW-1:CW];
    assign ox = other_reg[CW-1:0];
    assign oy = other_reg[PW-1:CW];

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DX:
            begin
                mul_a = gss_pkg::MUL_W'(dx_reg);
                mul_b = gss_pkg::MUL_W'(dx_reg);
            end
            ST_DY:
            begin
                mul_a = gss_pkg::MUL_W'(dy_reg);
                mul_b = gss_pkg::MUL_W'(dy_reg);
            end
            ST_DD:
            begin
                mul_a = gss_pkg::MUL_W'(d_reg);
                mul_b = gss_pkg::MUL_W'(d_reg);
            end
            ST_F1:
            begin
                mul_a = gss_pkg::MUL_W'(n_reg);
                mul_b = gss_pkg::MUL_W'(qsum_reg[gss_pkg::QHALF_W-1:0]);
            end
            ST_F2:
            begin
                mul_a = gss_pkg::MUL_W'(n_reg);
                mul_b = gss_pkg::MUL_W'(qsum_reg[gss_pkg::QSUM_W-1:gss_pkg::QHALF_W]);
            end
            ST_F3:
            begin
                mul_a = dsum_reg;
                mul_b = dsum_reg;
            end
            ST_F4:
            begin
                mul_a = gss_pkg::MUL_W'(n_reg);
                mul_b = gss_pkg::MUL_W'(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root step.
    always_comb
    begin
        sq_rem_sh   = {sq_rem_reg[gss_pkg::REM_W-3:0], sq_rad_reg[gss_pkg::WIDE_W-1 -: 2]};
        sq_trial    = {sq_root_reg, 2'b01};
        sq_ge       = sq_rem_sh >= sq_trial;
        sq_rem_next = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
    end

    // Divider step.
    assign dv_rem_sh = {dv_rem_reg, dv_quo_reg[gss_pkg::WIDE_W-1]};
    assign dv_ge     = dv_rem_sh >= {1'b0, nn_reg};

    // Row store: read the entry above and write the new point in the accept cycle.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mem_rd_reg       <= row_mem[col_reg];
            row_mem[col_reg] <= {y_coord, x_coord};
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (item_take)
            pt_reg <= {y_coord, x_coord};
        if (state_reg == ST_DIFF)
        begin
            dx_reg <= (px > ox) ? (px - ox) : (ox - px);
            dy_reg <= (py > oy) ? (py - oy) : (oy - py);
        end
        if (state_reg == ST_DY)
            sq_reg <= prod_reg[gss_pkg::WIDE_W-1:0];
        if (state_reg == ST_ROUND)
            d_reg <= gss_pkg::DIST_W'(sq_root_reg)
                   + gss_pkg::DIST_W'(sq_rem_reg > gss_pkg::REM_W'(sq_root_reg));
        if (state_reg == ST_F2)
            acc_reg <= prod_reg[gss_pkg::WIDE_W-1:0];
        if (state_reg == ST_F3)
            acc_reg <= acc_reg
                     + (gss_pkg::WIDE_W'(prod_reg[gss_pkg::CNT_W+gss_pkg::QHALF_W-1:0])
                        << gss_pkg::QHALF_W);
        if (state_reg == ST_F4)
            rhs_reg <= prod_reg[gss_pkg::WIDE_W-1:0];
        if (state_reg == ST_F5)
            nn_reg <= prod_reg[gss_pkg::NN_W-1:0];
        if (state_reg == ST_NEXT)
            other_reg <= left_pend_reg ? left_reg : mem_rd_reg;
    end

    // Control, accumulators and iterative units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cols_cfg_reg   <= gss_pkg::COLUMNS_RESET;
            rows_cfg_reg   <= gss_pkg::ROWS_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            left_pend_reg  <= 1'b0;
            above_pend_reg <= 1'b0;
            dsum_reg       <= '0;
            qsum_reg       <= '0;
            n_reg          <= '0;
            sq_rad_reg     <= '0;
            sq_rem_reg     <= '0;
            sq_root_reg    <= '0;
            sq_cnt_reg     <= '0;
            dv_quo_reg     <= '0;
            dv_rem_reg     <= '0;
            dv_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_flag_reg   <= 1'b0;
            out_spread_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && result_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        left_pend_reg  <= (col_reg != '0);
                        above_pend_reg <= (row_reg != '0);
                        state_reg      <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    if (left_pend_reg)
                    begin
                        left_pend_reg <= 1'b0;
                        state_reg     <= ST_DIFF;
                    end
                    else if (above_pend_reg)
                    begin
                        above_pend_reg <= 1'b0;
                        state_reg      <= ST_DIFF;
                    end
                    else
                        state_reg <= ST_FINPT;
                end
                ST_DIFF:  state_reg <= ST_DX;
                ST_DX:    state_reg <= ST_DY;
                ST_DY:    state_reg <= ST_SUM;
                ST_SUM:
                begin
                    // Align the 42-bit sum of squares under the top of the radicand.
                    sq_rad_reg  <= (sq_reg + prod_reg[gss_pkg::WIDE_W-1:0])
                                   << (gss_pkg::WIDE_W - 2 * gss_pkg::DIST_W);
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_cnt_reg  <= gss_pkg::SCNT_W'(gss_pkg::DIST_W);
                    state_reg   <= ST_SQRT;
                end
                ST_SQRT, ST_RSQRT:
                begin
                    sq_rad_reg  <= sq_rad_reg << 2;
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= {sq_root_reg[gss_pkg::ROOT_W-2:0], sq_ge};
                    sq_cnt_reg  <= sq_cnt_reg - gss_pkg::SCNT_W'(1);
                    if (sq_cnt_reg == gss_pkg::SCNT_W'(1))
                        state_reg <= (state_reg == ST_SQRT) ? ST_ROUND : ST_EMIT;
                end
                ST_ROUND: state_reg <= ST_DD;
                ST_DD:
                begin
                    dsum_reg  <= dsum_reg + gss_pkg::DSUM_W'(d_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    qsum_reg  <= qsum_reg + gss_pkg::QSUM_W'(prod_reg[2*gss_pkg::DIST_W-1:0]);
                    n_reg     <= n_reg + gss_pkg::CNT_W'(1);
                    state_reg <= ST_NEXT;
                end
                ST_FINPT:
                begin
                    left_reg <= pt_reg;
                    if (!last_col)
                    begin
                        col_reg   <= col_reg + gss_pkg::COL_W'(1);
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        col_reg <= '0;
                        if (!last_row)
                        begin
                            row_reg   <= row_reg + gss_pkg::ROW_W'(1);
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg   <= '0;
                            state_reg <= ST_F1;
                        end
                    end
                end
                ST_F1:
                begin
                    // No pairs: flag the grid and skip the statistics.
                    if (n_reg == '0)
                    begin
                        sq_root_reg <= '0;
                        state_reg   <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_F2;
                end
                ST_F2: state_reg <= ST_F3;
                ST_F3: state_reg <= ST_F4;
                ST_F4: state_reg <= ST_F5;
                ST_F5:
                begin
                    if (acc_reg > rhs_reg)
                    begin
                        dv_quo_reg <= acc_reg - rhs_reg;
                        dv_rem_reg <= '0;
                        dv_cnt_reg <= gss_pkg::DCNT_W'(gss_pkg::WIDE_W);
                        state_reg  <= ST_DIV;
                    end
                    else
                    begin
                        sq_root_reg <= '0;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_DIV:
                begin
                    dv_rem_reg <= dv_ge ? gss_pkg::NN_W'(dv_rem_sh - {1'b0, nn_reg})
                                        : gss_pkg::NN_W'(dv_rem_sh);
                    dv_quo_reg <= {dv_quo_reg[gss_pkg::WIDE_W-2:0], dv_ge};
                    dv_cnt_reg <= dv_cnt_reg - gss_pkg::DCNT_W'(1);
                    if (dv_cnt_reg == gss_pkg::DCNT_W'(1))
                    begin
                        sq_rad_reg  <= {dv_quo_reg[gss_pkg::WIDE_W-2:0], dv_ge};
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        sq_cnt_reg  <= gss_pkg::SCNT_W'(gss_pkg::ROOT_W);
                        state_reg   <= ST_RSQRT;
                    end
                end
                ST_EMIT:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || result_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_flag_reg   <= (n_reg == '0);
                        out_spread_reg <= (sq_root_reg > gss_pkg::ROOT_W'(gss_pkg::SPREAD_MAX))
                                          ? gss_pkg::SPREAD_MAX : CW'(sq_root_reg);
                        dsum_reg       <= '0;
                        qsum_reg       <= '0;
                        n_reg          <= '0;
                        left_reg       <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // A register write drops the grid in progress.
            if (cfg_write)
            begin
                if (paddr[2])
                    rows_cfg_reg <= pwdata[FW-1:0];
                else
                    cols_cfg_reg <= pwdata[FW-1:0];
                col_reg  <= '0;
                row_reg  <= '0;
                left_reg <= '0;
                dsum_reg <= '0;
                qsum_reg <= '0;
                n_reg    <= '0;
            end
        end
    end

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_flag_reg |-> out_spread_reg == '0)
        else $error("no_pairs result with nonzero spread");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        FW'(col_reg) < cols_eff)
        else $error("column index beyond grid width");

    a_take_next: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> state_reg == ST_NEXT)
        else $error("accepted point did not start pair processing");

    a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT || state_reg == ST_RSQRT) |-> sq_cnt_reg != '0)
        else $error("square root running with empty step count");

endmodule
